[hdl/bcv_pkg.sv]
// Shared types and constants for the block container validator.
// No dependencies; imported by every module of the block.
package bcv_pkg;

    typedef enum logic [6:0] {
        PH_TAG     = 7'b0000001,
        PH_COUNT   = 7'b0000010,
        PH_NAMELEN = 7'b0000100,
        PH_NAME    = 7'b0001000,
        PH_VERSION = 7'b0010000,
        PH_SIZE    = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_SHORT     = 2'd1,
        ERR_STRUCTURE = 2'd2,
        ERR_TAG       = 2'd3
    } err_code_t;

    localparam logic [1:0] CFG_MAX_NAME_LENGTH     = 2'd0;
    localparam logic [1:0] CFG_ACCEPTED_TAG_FIRST  = 2'd1;
    localparam logic [1:0] CFG_ACCEPTED_TAG_SECOND = 2'd2;

    localparam logic [7:0]  RST_MAX_NAME_LENGTH     = 8'd64;
    localparam logic [31:0] RST_ACCEPTED_TAG_FIRST  = 32'd14;
    localparam logic [31:0] RST_ACCEPTED_TAG_SECOND = 32'd15;

    localparam logic [7:0] NAME_CHAR_LO = 8'd32;
    localparam logic [7:0] NAME_CHAR_HI = 8'd126;
    localparam logic [3:0] MIN_FILE_LEN = 4'd12;

    typedef struct packed {
        logic [7:0]  max_name_length;
        logic [31:0] accepted_tag_first;
        logic [31:0] accepted_tag_second;
    } cfg_t;

    typedef struct packed {
        logic        valid_res;
        err_code_t   err_code;
        logic [31:0] tag_word;
        logic [15:0] blk_count;
    } result_t;

endpackage

[hdl/bcv_walker.sv]
// Byte walker: parses the container one byte per cycle while bytes are accepted, and forms the verdict.
// Depends on bcv_pkg.
module bcv_walker #(
    parameter int BLOCK_COUNT_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_accept,
    input  logic [7:0]      data_byte,
    input  logic            is_last,
    input  bcv_pkg::cfg_t   cfg,
    output logic            res_load,
    output bcv_pkg::result_t res
);
    import bcv_pkg::*;

    localparam logic [BLOCK_COUNT_BITS-1:0] CountMax = '1;
    localparam logic [BLOCK_COUNT_BITS-1:0] CountOne = {{(BLOCK_COUNT_BITS-1){1'b0}}, 1'b1};

    phase_t                      phase_reg, phase_next, walk_phase;
    logic [1:0]                  index_reg, index_next, walk_index;
    logic [31:0]                 shift_reg, shift_next, walk_shift;
    logic [31:0]                 remain_reg, remain_next, walk_remain;
    logic [31:0]                 tag_reg, tag_next, walk_tag;
    logic [BLOCK_COUNT_BITS-1:0] blocks_reg, blocks_next, walk_blocks;
    logic                        broken_reg, broken_next, walk_broken;
    logic [3:0]                  length_reg, length_next, walk_length;

    logic [31:0]                 shifted;
    logic [31:0]                 remain_dec;
    logic                        done4;
    logic                        at_boundary;
    logic [BLOCK_COUNT_BITS+15:0] blocks_wide;
    err_code_t                   code;

    assign shifted    = {shift_reg[23:0], data_byte};
    assign remain_dec = remain_reg - 32'd1;
    assign done4      = (index_reg == 2'd3);

    always_comb begin
        walk_phase  = phase_reg;
        walk_index  = index_reg;
        walk_shift  = shift_reg;
        walk_remain = remain_reg;
        walk_tag    = tag_reg;
        walk_blocks = blocks_reg;
        walk_broken = broken_reg;
        walk_length = (length_reg < MIN_FILE_LEN) ? length_reg + 4'd1 : length_reg;
        if (!broken_reg) begin
            unique case (phase_reg)
                PH_TAG: begin
                    walk_shift = shifted;
                    if (done4) begin
                        walk_tag   = shifted;
                        walk_shift = '0;
                        walk_index = '0;
                        walk_phase = PH_COUNT;
                    end else begin
                        walk_index = index_reg + 2'd1;
                    end
                end
                PH_COUNT: begin
                    if (done4) begin
                        walk_index = '0;
                        walk_phase = PH_NAMELEN;
                    end else begin
                        walk_index = index_reg + 2'd1;
                    end
                end
                PH_NAMELEN: begin
                    walk_shift = shifted;
                    if (done4) begin
                        if (shifted == 32'd0 || shifted > {24'd0, cfg.max_name_length}) begin
                            walk_broken = 1'b1;
                        end else begin
                            walk_remain = shifted;
                            walk_phase  = PH_NAME;
                        end
                        walk_shift = '0;
                        walk_index = '0;
                    end else begin
                        walk_index = index_reg + 2'd1;
                    end
                end
                PH_NAME: begin
                    if (data_byte < NAME_CHAR_LO || data_byte > NAME_CHAR_HI) begin
                        walk_broken = 1'b1;
                    end else begin
                        walk_remain = remain_dec;
                        if (remain_dec == 32'd0) begin
                            walk_phase = PH_VERSION;
                        end
                    end
                end
                PH_VERSION: begin
                    walk_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    walk_shift = shifted;
                    if (done4) begin
                        if (blocks_reg != CountMax) begin
                            walk_blocks = blocks_reg + CountOne;
                        end
                        walk_remain = shifted;
                        walk_phase  = (shifted != 32'd0) ? PH_PAYLOAD : PH_NAMELEN;
                        walk_shift  = '0;
                        walk_index  = '0;
                    end else begin
                        walk_index = index_reg + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    walk_remain = remain_dec;
                    if (remain_dec == 32'd0) begin
                        walk_phase = PH_NAMELEN;
                    end
                end
                default: begin
                    walk_broken = 1'b1;
                end
            endcase
        end
    end

    // Verdict from the state as it stands after this byte
    assign at_boundary = !walk_broken && (walk_phase == PH_NAMELEN) && (walk_index == 2'd0);

    always_comb begin
        if (walk_length < MIN_FILE_LEN) begin
            code = ERR_SHORT;
        end else if (!at_boundary || walk_blocks == '0) begin
            code = ERR_STRUCTURE;
        end else if (walk_tag != cfg.accepted_tag_first &&
                     walk_tag != cfg.accepted_tag_second) begin
            code = ERR_TAG;
        end else begin
            code = ERR_OK;
        end
    end

    assign blocks_wide     = {16'd0, walk_blocks};
    assign res.valid_res   = (code == ERR_OK);
    assign res.err_code    = code;
    assign res.tag_word    = walk_tag;
    assign res.blk_count   = blocks_wide[15:0];
    assign res_load        = byte_accept && is_last;

    // Drop all walk state after the last byte so the next byte opens a new file
    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        tag_next    = tag_reg;
        blocks_next = blocks_reg;
        broken_next = broken_reg;
        length_next = length_reg;
        if (byte_accept) begin
            if (is_last) begin
                phase_next  = PH_TAG;
                index_next  = '0;
                shift_next  = '0;
                remain_next = '0;
                tag_next    = '0;
                blocks_next = '0;
                broken_next = 1'b0;
                length_next = '0;
            end else begin
                phase_next  = walk_phase;
                index_next  = walk_index;
                shift_next  = walk_shift;
                remain_next = walk_remain;
                tag_next    = walk_tag;
                blocks_next = walk_blocks;
                broken_next = walk_broken;
                length_next = walk_length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            index_reg  <= '0;
            shift_reg  <= '0;
            remain_reg <= '0;
            tag_reg    <= '0;
            blocks_reg <= '0;
            broken_reg <= 1'b0;
            length_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            tag_reg    <= tag_next;
            blocks_reg <= blocks_next;
            broken_reg <= broken_next;
            length_reg <= length_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_broken_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (broken_reg && !(byte_accept && is_last)) |=> broken_reg)
        else $error("structure failure cleared before end of file");

    a_length_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= MIN_FILE_LEN)
        else $error("byte count ran past saturation");

    a_name_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME && !broken_reg) |->
            (remain_reg != 32'd0 && remain_reg <= {24'd0, 8'hFF}))
        else $error("name byte count out of range");
`endif

endmodule

[hdl/bcv_out_reg.sv]
// Result register: holds one verdict until the result channel takes it.
// Depends on bcv_pkg.
module bcv_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bcv_pkg::result_t res_in,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output bcv_pkg::result_t res_out
);
    import bcv_pkg::*;

    logic    full_reg, full_next;
    result_t data_reg;

    assign free      = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign res_out   = data_reg;

    always_comb begin
        full_next = full_reg;
        if (load) begin
            full_next = 1'b1;
        end else if (out_ready) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!full_reg || out_ready))
        else $error("verdict loaded over a pending one");

    a_flag_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (data_reg.valid_res == (data_reg.err_code == ERR_OK)))
        else $error("validity flag disagrees with error code");
`endif

endmodule

[hdl/block_container_validator_unit.sv]
// Block container validator, top level. Depends on bcv_pkg, bcv_walker, bcv_out_reg.
// Throughput: one byte per cycle. Latency: the verdict is on m_valid the cycle after
// the last byte is transferred. Bytes that are not last are taken even while a verdict
// waits; a last byte waits only until the result register is free.
// Reset (aresetn low, synchronous) clears the walk and the result register and returns
// the configuration registers to 64, 14 and 15.
module block_container_validator_unit #(
    parameter int BLOCK_COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [1:0]  m_error_code,
    output logic [31:0] m_build_tag,
    output logic [15:0] m_block_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bcv_pkg::*;

    cfg_t    cfg_reg;
    logic    byte_accept;
    logic    res_load;
    logic    out_free;
    result_t res_walk;
    result_t res_out;

    assign cfg_ready   = 1'b1;
    assign s_ready     = out_free || !s_is_last;
    assign byte_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_name_length     <= RST_MAX_NAME_LENGTH;
            cfg_reg.accepted_tag_first  <= RST_ACCEPTED_TAG_FIRST;
            cfg_reg.accepted_tag_second <= RST_ACCEPTED_TAG_SECOND;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_NAME_LENGTH:     cfg_reg.max_name_length     <= cfg_data[7:0];
                CFG_ACCEPTED_TAG_FIRST:  cfg_reg.accepted_tag_first  <= cfg_data;
                CFG_ACCEPTED_TAG_SECOND: cfg_reg.accepted_tag_second <= cfg_data;
                default: ;
            endcase
        end
    end

    bcv_walker #(
        .BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .data_byte   (s_data_byte),
        .is_last     (s_is_last),
        .cfg         (cfg_reg),
        .res_load    (res_load),
        .res         (res_walk)
    );

    bcv_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .res_in    (res_walk),
        .free      (out_free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .res_out   (res_out)
    );

    assign m_valid_res   = res_out.valid_res;
    assign m_error_code  = res_out.err_code;
    assign m_build_tag   = res_out.tag_word;
    assign m_block_count = res_out.blk_count;

endmodule

[tb/sv/tb_block_container_validator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_container_validator_unit: byte streams of
// container files with random idling, checked against a built-in scan model or
// a table of expected verdicts. Depends on bcv_pkg and the block's RTL.
module tb_block_container_validator_unit;
    import bcv_pkg::*;

    localparam int          NUM_ROWS         = 13;
    localparam int          NUM_PHASES       = 6;
    localparam int          PHASE_BYTES      = 260;
    localparam int          WATCHDOG_LIMIT   = 4000;
    localparam int          HOLD_CYCLES      = 400;
    localparam int          DRAIN_CYCLES     = 4;
    localparam logic [15:0] COUNT_CAP        = 16'hFFFF;
    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [5:0]   len;
        logic [319:0] body;     // last byte of the file in the low lane
        logic         typed;
        result_t      want;
    } file_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_is_last   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_valid_res;
    logic [1:0]  m_error_code;
    logic [31:0] m_build_tag;
    logic [15:0] m_block_count;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = 2'd0;
    logic [31:0] cfg_data    = 32'd0;

    // scan model: configuration copy and walk state
    logic [7:0]  lim_name;
    logic [31:0] tag_a;
    logic [31:0] tag_b;
    phase_t      walk_phase;
    logic [1:0]  fld_idx;
    logic [31:0] shift_acc;
    logic [31:0] remain;
    logic [31:0] tag_held;
    logic [15:0] blocks;
    logic        broken;
    logic [3:0]  seen_len;

    result_t     verdicts_due [$];
    logic [7:0]  file_bytes [$];
    file_row_t   dir_rows [NUM_ROWS];
    int          mismatches   = 0;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    int          gap_odds     = 2;
    bit          idle_on      = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;

    block_container_validator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_error_code  (m_error_code),
        .m_build_tag   (m_build_tag),
        .m_block_count (m_block_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    task automatic restart_walk;
        walk_phase = PH_TAG;
        fld_idx    = 2'd0;
        shift_acc  = 32'd0;
        remain     = 32'd0;
        tag_held   = 32'd0;
        blocks     = 16'd0;
        broken     = 1'b0;
        seen_len   = 4'd0;
    endtask

    // Advance the scan by one byte; on the last byte produce the verdict.
    task automatic scan_byte(input logic [7:0] b, input logic last,
                             output bit fired, output result_t v);
        logic        done4;
        logic        boundary;
        err_code_t   code;
        fired = 1'b0;
        v     = '0;
        done4 = (fld_idx == 2'd3);
        if (seen_len < MIN_FILE_LEN)
            seen_len++;
        if (!broken) begin
            case (walk_phase)
                PH_TAG: begin
                    shift_acc = {shift_acc[23:0], b};
                    if (done4) begin
                        tag_held   = shift_acc;
                        shift_acc  = 32'd0;
                        fld_idx    = 2'd0;
                        walk_phase = PH_COUNT;
                    end else begin
                        fld_idx++;
                    end
                end
                PH_COUNT: begin
                    if (done4) begin
                        fld_idx    = 2'd0;
                        walk_phase = PH_NAMELEN;
                    end else begin
                        fld_idx++;
                    end
                end
                PH_NAMELEN: begin
                    shift_acc = {shift_acc[23:0], b};
                    if (done4) begin
                        if (shift_acc == 32'd0 || shift_acc > {24'd0, lim_name}) begin
                            broken = 1'b1;
                        end else begin
                            remain     = shift_acc;
                            walk_phase = PH_NAME;
                        end
                        shift_acc = 32'd0;
                        fld_idx   = 2'd0;
                    end else begin
                        fld_idx++;
                    end
                end
                PH_NAME: begin
                    if (b < NAME_CHAR_LO || b > NAME_CHAR_HI) begin
                        broken = 1'b1;
                    end else begin
                        remain--;
                        if (remain == 32'd0)
                            walk_phase = PH_VERSION;
                    end
                end
                PH_VERSION: walk_phase = PH_SIZE;
                PH_SIZE: begin
                    shift_acc = {shift_acc[23:0], b};
                    if (done4) begin
                        if (blocks != COUNT_CAP)
                            blocks++;
                        remain = shift_acc;
                        if (remain != 32'd0)
                            walk_phase = PH_PAYLOAD;
                        else
                            walk_phase = PH_NAMELEN;
                        shift_acc = 32'd0;
                        fld_idx   = 2'd0;
                    end else begin
                        fld_idx++;
                    end
                end
                PH_PAYLOAD: begin
                    remain--;
                    if (remain == 32'd0)
                        walk_phase = PH_NAMELEN;
                end
                default: broken = 1'b1;
            endcase
        end
        if (last) begin
            boundary = !broken && walk_phase == PH_NAMELEN && fld_idx == 2'd0;
            if (seen_len < MIN_FILE_LEN)
                code = ERR_SHORT;
            else if (!boundary || blocks == 16'd0)
                code = ERR_STRUCTURE;
            else if (tag_held != tag_a && tag_held != tag_b)
                code = ERR_TAG;
            else
                code = ERR_OK;
            v.valid_res = (code == ERR_OK);
            v.err_code  = code;
            v.tag_word  = tag_held;
            v.blk_count = blocks;
            fired = 1'b1;
            restart_walk();
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h, want %0h", what, got, want);
    endtask

    task automatic check_verdict;
        result_t want;
        if (verdicts_due.size() == 0) begin
            note_mismatch("verdict with none pending, tag", m_build_tag, 32'd0);
            return;
        end
        want = verdicts_due.pop_front();
        if (m_valid_res !== want.valid_res)
            note_mismatch("validity", 32'(m_valid_res), 32'(want.valid_res));
        if (m_error_code !== want.err_code)
            note_mismatch("error code", 32'(m_error_code), 32'(want.err_code));
        if (m_build_tag !== want.tag_word)
            note_mismatch("build tag", m_build_tag, want.tag_word);
        if (m_block_count !== want.blk_count)
            note_mismatch("block count", 32'(m_block_count), 32'(want.blk_count));
    endtask

    // Offer one byte, hold it until the transfer, then update the scan model.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input result_t want);
        bit      fired;
        result_t v;
        if (idle_on && gap_odds != 0 && $urandom_range(1, gap_odds * 4) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(b, last, fired, v);
        if (fired)
            verdicts_due.insert(verdicts_due.size(), typed ? want : v);
    endtask

    task automatic send_file;
        gap_odds = $urandom_range(0, 3);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
    endtask

    // Drop valid and wait for every verdict, plus the result register latency.
    task automatic settle;
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MAX_NAME_LENGTH:     lim_name = val[7:0];
            CFG_ACCEPTED_TAG_FIRST:  tag_a = val;
            CFG_ACCEPTED_TAG_SECOND: tag_b = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] max_len, input logic [31:0] first,
                                  input logic [31:0] second);
        write_reg(CFG_MAX_NAME_LENGTH, {8'($urandom), 16'd0, max_len});
        write_reg(CFG_UNUSED_INDEX, $urandom);
        write_reg(CFG_ACCEPTED_TAG_FIRST, first);
        write_reg(CFG_ACCEPTED_TAG_SECOND, second);
        cfg_valid <= 1'b0;
    endtask

    task automatic append_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            append_byte(w[8*i +: 8]);
    endtask

    // Build one file: mostly well formed, some with a bad length, a bad name
    // character or later damage, and some plain noise.
    task automatic build_file;
        int          pick;
        int          blocks_n;
        int          nlen;
        int          psize;
        int          cut;
        int          pos;
        logic [31:0] tag;
        logic [7:0]  ch;
        bit          damaged;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 30)) append_byte(8'($urandom));
            return;
        end
        case ($urandom_range(0, 5))
            0, 1:    tag = tag_a;
            2, 3:    tag = tag_b;
            4:       tag = $urandom;
            default: tag = $urandom_range(0, 20);
        endcase
        push_word(tag);
        push_word($urandom);
        blocks_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        damaged  = 1'b0;
        for (int k = 0; k < blocks_n && !damaged; k++) begin
            if (pick < 14 && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_word(32'd0);
                    1:       push_word({24'd0, lim_name} + 32'd1);
                    default: push_word($urandom);
                endcase
                damaged = 1'b1;
            end else begin
                if (lim_name == 8'd0)
                    nlen = $urandom_range(1, 3);
                else if ($urandom_range(0, 19) == 0)
                    nlen = lim_name;
                else
                    nlen = $urandom_range(1, (lim_name < 8) ? lim_name : 8);
                push_word(nlen);
                for (int j = 0; j < nlen; j++) begin
                    case ($urandom_range(0, 15))
                        0:       ch = NAME_CHAR_LO;
                        1:       ch = NAME_CHAR_HI;
                        default: ch = 8'($urandom_range(32, 126));
                    endcase
                    if (pick >= 14 && pick < 20 && $urandom_range(0, 7) == 0)
                        ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                         : 8'($urandom_range(127, 255));
                    append_byte(ch);
                end
                append_byte(8'($urandom));
                psize = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                push_word(psize);
                repeat (psize) append_byte(8'($urandom));
            end
        end
        if (damaged)
            repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
        if (pick >= 20 && pick < 32) begin
            case ($urandom_range(0, 2))
                0: begin
                    cut = $urandom_range(1, file_bytes.size() - 1);
                    while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                end
                1: begin
                    pos = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[pos] = 8'($urandom);
                end
                default: repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
            endcase
        end
    endtask

    // Result side: check each transfer, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                check_verdict();
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_on && stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int r;
        int i;
        int ph;
        int phase_bytes;
        lim_name = RST_MAX_NAME_LENGTH;
        tag_a    = RST_ACCEPTED_TAG_FIRST;
        tag_b    = RST_ACCEPTED_TAG_SECOND;
        restart_walk();

        dir_rows[0]  = '{6'd1, 320'hA5, 1'b1, '{1'b0, ERR_SHORT, 32'h0, 16'd0}};
        dir_rows[1]  = '{6'd4, 320'hFFFFFFFF, 1'b1,
                         '{1'b0, ERR_SHORT, 32'hFFFF_FFFF, 16'd0}};
        dir_rows[2]  = '{6'd11, 320'h0000000E_12345678_000000, 1'b1,
                         '{1'b0, ERR_SHORT, 32'hE, 16'd0}};
        // zero name length right at twelve bytes
        dir_rows[3]  = '{6'd12, 320'h0000000E_00000000_00000000, 1'b1,
                         '{1'b0, ERR_STRUCTURE, 32'hE, 16'd0}};
        dir_rows[4]  = '{6'd19, 320'h0000000F_FFFFFFFF_00000002_7E20_FF_00000000, 1'b1,
                         '{1'b1, ERR_OK, 32'hF, 16'd1}};
        dir_rows[5]  = '{6'd19, 320'h00000000_00000000_00000001_41_00_00000001_80, 1'b1,
                         '{1'b0, ERR_TAG, 32'h0, 16'd1}};
        // bad name character, then bytes after the failure
        dir_rows[6]  = '{6'd16, 320'h0000000E_00000000_00000002_41_7F_FF_00, 1'b1,
                         '{1'b0, ERR_STRUCTURE, 32'hE, 16'd0}};
        dir_rows[7]  = '{6'd14, 320'h0000000F_00000000_00000001_1F_20, 1'b1,
                         '{1'b0, ERR_STRUCTURE, 32'hF, 16'd0}};
        dir_rows[8]  = '{6'd12, 320'h0000000E_00000000_00000041, 1'b1,
                         '{1'b0, ERR_STRUCTURE, 32'hE, 16'd0}};
        // payload runs past the end: block still counted
        dir_rows[9]  = '{6'd20, 320'h0000000F_00000000_00000001_5A_00_00000010_11_22, 1'b1,
                         '{1'b0, ERR_STRUCTURE, 32'hF, 16'd1}};
        dir_rows[10] = '{6'd20, 320'h0000000E_00000000_00000001_20_01_00000000_0000,
                         1'b0, '0};
        dir_rows[11] = '{6'd31,
                         320'h0000000F_AABBCCDD_00000001_7E_02_00000001_C3_00000003_414243_10_00000000,
                         1'b0, '0};
        dir_rows[12] = '{6'd13, 320'h0000000E_00000000_FFFFFFFF_00, 1'b0, '0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < NUM_ROWS; r++)
            for (i = 0; i < dir_rows[r].len; i++)
                send_byte(dir_rows[r].body[8*(dir_rows[r].len - 1 - i) +: 8],
                          i == dir_rows[r].len - 1, dir_rows[r].typed, dir_rows[r].want);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_settings(8'd255, 32'h0, 32'hFFFF_FFFF);
                1: apply_settings(8'd1, $urandom, RST_ACCEPTED_TAG_FIRST);
                2: apply_settings(8'd0, RST_ACCEPTED_TAG_SECOND, $urandom);
                3: apply_settings(8'($urandom_range(2, 40)), $urandom_range(0, 20), $urandom);
                4: apply_settings(8'd8, RST_ACCEPTED_TAG_FIRST, RST_ACCEPTED_TAG_SECOND);
                default: apply_settings(RST_MAX_NAME_LENGTH, RST_ACCEPTED_TAG_FIRST,
                                        RST_ACCEPTED_TAG_SECOND);
            endcase
            if (ph == 4)
                hold_request = 1'b1;
            if (ph == NUM_PHASES - 1)
                idle_on = 1'b0;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_file();
                send_file();
                phase_bytes += file_bytes.size();
            end
            settle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
